// ----- src/fvn4d_pkg.sv -----
// ----------------------------------------------------------------------------
// fvn4d_pkg: shared types and helpers for the 4D fractal value noise unit
// Holds the octave context record handed from cell to cell and the
// constant-divisor arithmetic used by the lattice hash and corner values.
// ----------------------------------------------------------------------------
package fvn4d_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] RegOctaveCount  = 2'd0;
  localparam logic [1:0] RegFrequencyStep = 2'd1;
  localparam logic [1:0] RegAmplitudeStep = 2'd2;

  localparam logic [3:0]  OctaveCountRst   = 4'd4;
  localparam logic [15:0] FrequencyStepRst = 16'd8192;
  localparam logic [15:0] AmplitudeStepRst = 16'd8192;

  // Starting frequency 1.0 in Q16.16, starting amplitude 1.0 in Q18.14
  localparam logic [31:0] FreqOne = 32'h0001_0000;
  localparam logic [31:0] AmpOne  = 32'h0000_4000;

  // floor(2^31 / 289), quotient estimate is low by at most one
  localparam logic [22:0] Recip289 = 23'd7430739;

  // Context of one request as it travels down the octave chain
  typedef struct packed {
    logic             valid;
    logic [3:0][31:0] coord;   // signed Q16.16, index 0 is x
    logic [31:0]      freq;    // unsigned Q16.16
    logic [31:0]      amp;     // unsigned Q18.14
    logic [31:0]      asum;    // saturated amplitude sum
    logic [63:0]      total;   // signed weighted sum, Q30
  } ctx_t;

  // Quotient of x / 289 by reciprocal multiply and one correction
  function automatic logic [16:0] div289(input logic [24:0] x);
    logic [47:0] p;
    logic [16:0] q;
    logic [25:0] r;
    p = 48'(x) * 48'(Recip289);
    q = p[47:31];
    r = 26'(x) - 26'(q) * 26'd289;
    if (r >= 26'd289) q = q + 17'd1;
    return q;
  endfunction

  function automatic logic [8:0] mod289(input logic [24:0] x);
    logic [16:0] q;
    logic [25:0] r;
    q = div289(x);
    r = 26'(x) - 26'(q) * 26'd289;
    return r[8:0];
  endfunction

  // One link of the chained hash: (h*34+1)*h + c, not yet reduced
  function automatic logic [22:0] hash_link(input logic [8:0] h, input logic [8:0] c);
    logic [13:0] m;
    m = 14'(h) * 14'd34 + 14'd1;
    return 23'(m) * 23'(h) + 23'(c);
  endfunction

  // Map a hash to round((2h-289) * 2^16 / 289), half away from zero
  function automatic logic signed [17:0] corner_value(input logic [8:0] h);
    logic        neg;
    logic [9:0]  h2;
    logic [9:0]  mag;
    logic [24:0] n;
    logic [16:0] q;
    neg = (h < 9'd145);
    h2  = {h, 1'b0};
    mag = neg ? (10'd289 - h2) : (h2 - 10'd289);
    n   = {mag[8:0], 16'b0} + 25'd144;
    q   = div289(n);
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

// ----- src/fvn4d_octave_cell.sv -----
// ----------------------------------------------------------------------------
// fvn4d_octave_cell: one octave of 4D value noise
// Scales the point, hashes the 16 lattice corners, fades and blends them, and
// folds the weighted noise into the request context. Sixteen stages, one
// request per cycle while enabled; cells past the octave count pass through.
// ----------------------------------------------------------------------------
module fvn4d_octave_cell
  import fvn4d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [4:0]  cell_idx_i,
  input  logic [4:0]  octs_i,
  input  logic [15:0] freq_step_i,
  input  logic [15:0] amp_step_i,
  input  ctx_t        ctx_i,
  output ctx_t        ctx_o
);

  localparam int unsigned Depth = 16;
  localparam int unsigned FDepth = 10;

  function automatic logic signed [17:0] lerp(input logic signed [17:0] a,
                                              input logic signed [17:0] b,
                                              input logic [16:0] f);
    logic signed [18:0] diff;
    logic signed [36:0] p;
    diff = 19'(b) - 19'(a);
    p    = $signed({1'b0, f}) * diff;
    return a + 18'(p >>> 16);
  endfunction

  ctx_t ctx_q [Depth];
  ctx_t ctx_last_d;

  logic signed [31:0] s_q   [4];
  logic [8:0]         r0_q  [4];
  logic [15:0]        t_q   [4];
  logic signed [43:0] ip_q  [4];
  logic [15:0]        t2_q  [4];
  logic [8:0]         r0c_q [4];
  logic [8:0]         r1_q  [4];
  logic signed [21:0] a_q   [4];
  logic [15:0]        t3_q  [4];
  logic [3:0][16:0]   f_sh_q [FDepth];

  logic [22:0] p1_q [16];
  logic [8:0]  pk2_q [16];
  logic [8:0]  pk3d_q [16];
  logic [8:0]  h1_q [16];
  logic [8:0]  pk2e_q [16];
  logic [8:0]  pk3e_q [16];
  logic [22:0] p2_q [16];
  logic [8:0]  pk3f_q [16];
  logic [8:0]  h2_q [16];
  logic [8:0]  pk3g_q [16];
  logic [22:0] p3_q [16];
  logic [8:0]  h3_q [16];
  logic signed [17:0] cv_q [16];
  logic signed [17:0] l0_q [8];
  logic signed [17:0] l1_q [4];
  logic signed [17:0] l2_q [2];
  logic signed [17:0] n_q;
  logic signed [50:0] pa_q;
  logic [31:0] an_q, fn_q, sn_q;

  logic active;
  assign active = (cell_idx_i < octs_i);

  // Scale coordinates, lattice residues and fade products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int d = 0; d < 4; d++) begin
        logic signed [64:0] prod;
        logic signed [48:0] sh;
        logic [15:0]        t;
        logic signed [21:0] ts;
        logic signed [21:0] inner;
        logic [31:0]        tt;
        logic [31:0]        ttt;
        logic signed [38:0] fa;
        logic signed [22:0] fsh;
        prod = $signed(ctx_i.coord[d]) * $signed({1'b0, ctx_i.freq});
        sh   = 49'(prod >>> 16);
        if (sh > 49'sd2147483647) s_q[d] <= 32'sh7FFF_FFFF;
        else if (sh < -49'sd2147483648) s_q[d] <= 32'sh8000_0000;
        else s_q[d] <= sh[31:0];

        // stage B: residue of the cell index and first fade products
        t      = s_q[d][15:0];
        ts     = $signed({6'b0, t});
        inner  = ts * 22'sd6 - 22'sd983040;
        r0_q[d] <= mod289(25'({~s_q[d][31], s_q[d][30:16]}) + 25'd178);
        t_q[d]  <= t;
        ip_q[d] <= ts * inner;
        tt      = 32'(t) * 32'(t);
        t2_q[d] <= tt[31:16];

        // stage C: upper residue and second fade products
        r0c_q[d] <= r0_q[d];
        r1_q[d]  <= (r0_q[d] == 9'd288) ? 9'd0 : r0_q[d] + 9'd1;
        a_q[d]   <= 22'(ip_q[d] >>> 16) + 22'sd655360;
        ttt      = 32'(t2_q[d]) * 32'(t_q[d]);
        t3_q[d]  <= ttt[31:16];

        // stage D: fade value clamped to [0, 1.0]
        fa  = $signed({1'b0, t3_q[d]}) * a_q[d];
        fsh = 23'(fa >>> 16);
        if (fsh < 23'sd0) f_sh_q[0][d] <= 17'd0;
        else if (fsh > 23'sd65536) f_sh_q[0][d] <= 17'd65536;
        else f_sh_q[0][d] <= fsh[16:0];
      end
      for (int j = 1; j < FDepth; j++) f_sh_q[j] <= f_sh_q[j-1];
    end
  end

  // Hash the 16 corners, three links of the chain
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 16; c++) begin
        logic [8:0] pk0, pk1;
        pk0 = c[0] ? r1_q[0] : r0c_q[0];
        pk1 = c[1] ? r1_q[1] : r0c_q[1];
        p1_q[c]   <= hash_link(pk0, pk1);
        pk2_q[c]  <= c[2] ? r1_q[2] : r0c_q[2];
        pk3d_q[c] <= c[3] ? r1_q[3] : r0c_q[3];

        h1_q[c]   <= mod289(25'(p1_q[c]));
        pk2e_q[c] <= pk2_q[c];
        pk3e_q[c] <= pk3d_q[c];

        p2_q[c]   <= hash_link(h1_q[c], pk2e_q[c]);
        pk3f_q[c] <= pk3e_q[c];

        h2_q[c]   <= mod289(25'(p2_q[c]));
        pk3g_q[c] <= pk3f_q[c];

        p3_q[c] <= hash_link(h2_q[c], pk3g_q[c]);
        h3_q[c] <= mod289(25'(p3_q[c]));
        cv_q[c] <= corner_value(h3_q[c]);
      end
    end
  end

  // Blend along x, y, z, w, then weight and advance amplitude and frequency
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [47:0] ap;
      logic [47:0] fp;
      logic [32:0] ssum;
      for (int k = 0; k < 8; k++) l0_q[k] <= lerp(cv_q[2*k], cv_q[2*k+1], f_sh_q[6][0]);
      for (int k = 0; k < 4; k++) l1_q[k] <= lerp(l0_q[2*k], l0_q[2*k+1], f_sh_q[7][1]);
      for (int k = 0; k < 2; k++) l2_q[k] <= lerp(l1_q[2*k], l1_q[2*k+1], f_sh_q[8][2]);
      n_q <= lerp(l2_q[0], l2_q[1], f_sh_q[9][3]);

      pa_q <= n_q * $signed({1'b0, ctx_q[13].amp});
      ap   = 48'(ctx_q[13].amp) * 48'(amp_step_i);
      fp   = 48'(ctx_q[13].freq) * 48'(freq_step_i);
      ssum = 33'(ctx_q[13].asum) + 33'(ctx_q[13].amp);
      an_q <= (ap[47:46] != 2'b0) ? 32'hFFFF_FFFF : ap[45:14];
      fn_q <= (fp[47:44] != 4'b0) ? 32'hFFFF_FFFF : fp[43:12];
      sn_q <= ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
    end
  end

  // Fold this octave into the context, or pass it on untouched
  always_comb begin
    ctx_last_d = ctx_q[14];
    if (active) begin
      ctx_last_d.freq  = fn_q;
      ctx_last_d.amp   = an_q;
      ctx_last_d.asum  = sn_q;
      ctx_last_d.total = ctx_q[14].total + 64'(pa_q);
    end
  end

  // Advance the context line alongside the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) ctx_q[k] <= '0;
    end else if (en_i) begin
      ctx_q[0] <= ctx_i;
      for (int k = 1; k < Depth - 1; k++) ctx_q[k] <= ctx_q[k-1];
      ctx_q[Depth-1] <= ctx_last_d;
    end
  end

  assign ctx_o = ctx_q[Depth-1];

endmodule

// ----- src/fvn4d_divider.sv -----
// ----------------------------------------------------------------------------
// fvn4d_divider: normalize the weighted sum by the amplitude sum
// Restoring division, one quotient bit per stage, rounded half away from zero
// and saturated to Q1.15.
// ----------------------------------------------------------------------------
module fvn4d_divider
  import fvn4d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ctx_t               ctx_i,
  output logic               valid_o,
  output logic signed [15:0] noise_o
);

  localparam int unsigned QBits = 17;
  localparam int unsigned Lines = QBits + 1;

  logic        v0_q;
  logic        neg0_q;
  logic [65:0] num0_q;
  logic [31:0] asum0_q;

  logic        vld_q  [Lines];
  logic        neg_q  [Lines];
  logic        ovf_q  [Lines];
  logic [65:0] rem_q  [Lines];
  logic [QBits-1:0] quo_q [Lines];
  logic [31:0] asum_q [Lines];

  logic        out_vld_q;
  logic signed [15:0] noise_q;

  // Valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int i = 0; i < Lines; i++) vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= ctx_i.valid;
      vld_q[0] <= v0_q;
      for (int i = 1; i < Lines; i++) vld_q[i] <= vld_q[i-1];
      out_vld_q <= vld_q[Lines-1];
    end
  end

  // Numerator with the rounding term, overflow check, then one bit a stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      logic [63:0] mag;
      logic [65:0] dsh;
      logic [QBits:0] qx;
      mag = ctx_i.total[63] ? (64'd0 - ctx_i.total) : ctx_i.total;
      neg0_q  <= ctx_i.total[63];
      num0_q  <= 66'(mag) + 66'(ctx_i.asum);
      asum0_q <= ctx_i.asum;

      neg_q[0]  <= neg0_q;
      ovf_q[0]  <= (num0_q >= (66'(asum0_q) << (QBits + 1)));
      rem_q[0]  <= num0_q;
      quo_q[0]  <= '0;
      asum_q[0] <= asum0_q;

      for (int i = 1; i < Lines; i++) begin
        dsh = 66'(asum_q[i-1]) << (QBits + 1 - i);
        neg_q[i]  <= neg_q[i-1];
        ovf_q[i]  <= ovf_q[i-1];
        asum_q[i] <= asum_q[i-1];
        if (rem_q[i-1] >= dsh) begin
          rem_q[i] <= rem_q[i-1] - dsh;
          quo_q[i] <= {quo_q[i-1][QBits-2:0], 1'b1};
        end else begin
          rem_q[i] <= rem_q[i-1];
          quo_q[i] <= {quo_q[i-1][QBits-2:0], 1'b0};
        end
      end

      // apply the sign and saturate
      qx = {1'b0, quo_q[Lines-1]};
      if (!neg_q[Lines-1]) begin
        if (ovf_q[Lines-1] || quo_q[Lines-1] > 17'd32767) noise_q <= 16'sh7FFF;
        else noise_q <= quo_q[Lines-1][15:0];
      end else begin
        if (ovf_q[Lines-1] || quo_q[Lines-1] >= 17'd32768) noise_q <= 16'sh8000;
        else noise_q <= 16'(18'd0 - qx);
      end
    end
  end

  assign valid_o = out_vld_q;
  assign noise_o = noise_q;

endmodule

// ----- src/fractal_value_noise_4d_unit.sv -----
// ----------------------------------------------------------------------------
// fractal_value_noise_4d_unit: fractal 4D value noise
// Top level: configuration registers, chain of octave cells, normalizer.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle at full rate: a row of OCTAVES_MAX octave
// cells, each a 16-stage pipeline, hands every request on to its neighbor, and
// cells past the configured octave count pass the request through. The time
// through the unit does not depend on the octave count. When the output is
// held, the whole pipeline holds and no new request is taken. Configuration
// must be written only while the unit is empty; the unit does not enforce it.
module fractal_value_noise_4d_unit
  import fvn4d_pkg::*;
#(
  parameter int unsigned OCTAVES_MAX = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic signed [31:0] coord_w_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] noise_value_o
);

  logic [3:0]  octave_count_q;
  logic [15:0] frequency_step_q;
  logic [15:0] amplitude_step_q;
  logic [4:0]  octs;
  logic        adv;
  ctx_t        chain [OCTAVES_MAX+1];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_count_q   <= OctaveCountRst;
      frequency_step_q <= FrequencyStepRst;
      amplitude_step_q <= AmplitudeStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegOctaveCount:   octave_count_q   <= cfg_data_i[3:0];
        RegFrequencyStep: frequency_step_q <= cfg_data_i;
        RegAmplitudeStep: amplitude_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective octave count: zero means one, clamp to the cell count
  always_comb begin
    octs = (octave_count_q == 4'd0) ? 5'd1 : {1'b0, octave_count_q};
    if (octs > 5'(OCTAVES_MAX)) octs = 5'(OCTAVES_MAX);
  end

  // Hold the pipeline while a result waits
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    chain[0].valid = in_valid_i;
    chain[0].coord = {coord_w_i, coord_z_i, coord_y_i, coord_x_i};
    chain[0].freq  = FreqOne;
    chain[0].amp   = AmpOne;
    chain[0].asum  = '0;
    chain[0].total = '0;
  end

  for (genvar i = 0; i < OCTAVES_MAX; i++) begin : g_cell
    fvn4d_octave_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (adv),
      .cell_idx_i  (5'(i)),
      .octs_i      (octs),
      .freq_step_i (frequency_step_q),
      .amp_step_i  (amplitude_step_q),
      .ctx_i       (chain[i]),
      .ctx_o       (chain[i+1])
    );
  end

  fvn4d_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .ctx_i   (chain[OCTAVES_MAX]),
    .valid_o (out_valid_o),
    .noise_o (noise_value_o)
  );

endmodule

// ----- tb/sv/fractal_value_noise_4d_unit_tb.sv -----
// ----------------------------------------------------------------------------
// fractal_value_noise_4d_unit_tb: self-checking bench for the 4D fBm noise unit
// Drives random and corner-case points under several octave, lacunarity and
// gain settings, predicts each noise value in fixed point and compares in order.
// ----------------------------------------------------------------------------
module fractal_value_noise_4d_unit_tb;
  import fvn4d_pkg::*;

  localparam int unsigned OctMax = 8;
  localparam int unsigned Latency = 16 * OctMax + 20;

  // Scoreboard: fixed-point noise predictor plus queue of pending noise values
  class noise_board;
    logic [3:0]  oct_cnt = OctaveCountRst;
    logic [15:0] freq_step = FrequencyStepRst;
    logic [15:0] amp_step = AmplitudeStepRst;
    logic signed [15:0] pending_noise[$];
    int mismatches = 0;

    function automatic longint fshr(longint v, int sh);
      return v >>> sh;
    endfunction

    function automatic longint fade_q16(longint t);
      longint a, t3, f;
      a = fshr(t * (6 * t - 15 * 65536), 16) + 10 * 65536;
      t3 = fshr(fshr(t * t, 16) * t, 16);
      f = fshr(t3 * a, 16);
      if (f < 0) f = 0;
      if (f > 65536) f = 65536;
      return f;
    endfunction

    function automatic longint lattice_value(int unsigned h);
      longint d, q;
      d = 2 * longint'(h) - 289;
      q = (((d < 0) ? -d : d) * 65536 + 144) / 289;
      return (d < 0) ? -q : q;
    endfunction

    function automatic longint octave_noise(longint s[4]);
      int unsigned r0[4], r1[4], h, p;
      longint f[4], v[16], lat, r;
      int n;
      for (int d = 0; d < 4; d++) begin
        lat = fshr(s[d], 16);
        r = lat % 289;
        if (r < 0) r += 289;
        r0[d] = 32'(r);
        r1[d] = 32'((r + 1) % 289);
        f[d] = fade_q16(s[d] - lat * 65536);
      end
      for (int c = 0; c < 16; c++) begin
        h = ((c & 1) != 0) ? r1[0] : r0[0];
        for (int d = 1; d < 4; d++) begin
          p = ((c >> d) & 1) ? r1[d] : r0[d];
          h = ((h * 34 + 1) * h + p) % 289;
        end
        v[c] = lattice_value(h);
      end
      n = 16;
      for (int d = 0; d < 4; d++) begin
        n = n / 2;
        for (int k = 0; k < n; k++) v[k] = v[2*k] + fshr(f[d] * (v[2*k+1] - v[2*k]), 16);
      end
      return v[0];
    endfunction

    function void note_request(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] cw);
      longint crd[4], s[4], total, q, res;
      longint unsigned freq, amp, asum, mag, den;
      int octs;
      crd[0] = longint'($signed(cx)); crd[1] = longint'($signed(cy));
      crd[2] = longint'($signed(cz)); crd[3] = longint'($signed(cw));
      freq = 65536; amp = 16384; asum = 0; total = 0;
      octs = oct_cnt;
      if (octs == 0) octs = 1;
      if (octs > OctMax) octs = OctMax;
      for (int o = 0; o < octs; o++) begin
        for (int d = 0; d < 4; d++) begin
          s[d] = fshr(crd[d] * longint'(freq), 16);
          if (s[d] > 64'sd2147483647) s[d] = 64'sd2147483647;
          if (s[d] < -64'sd2147483648) s[d] = -64'sd2147483648;
        end
        total += octave_noise(s) * longint'(amp);
        asum = asum + amp; if (asum > 32'hFFFFFFFF) asum = 32'hFFFFFFFF;
        amp = (amp * amp_step) >> 14; if (amp > 32'hFFFFFFFF) amp = 32'hFFFFFFFF;
        freq = (freq * freq_step) >> 12; if (freq > 32'hFFFFFFFF) freq = 32'hFFFFFFFF;
      end
      den = asum * 2;
      mag = (total < 0) ? -total : total;
      q = (mag + den / 2) / den;
      res = (total < 0) ? -q : q;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      pending_noise.push_back(16'(res));
    endfunction

    function void check_result(logic signed [15:0] got);
      logic signed [15:0] exp_v;
      if (pending_noise.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("noise result with no request pending: %0d", got);
        return;
      end
      exp_v = pending_noise.pop_front();
      if (got !== exp_v) begin
        mismatches++;
        if (mismatches <= 10) $display("noise_value mismatch: expected %0d, got %0d", exp_v, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = RegOctaveCount;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0, coord_w_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] noise_value_o;

  noise_board board = new();
  bit quiet_tail = 1'b0;
  bit hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  fractal_value_noise_4d_unit #(.OCTAVES_MAX(OctMax)) u_top (.*);

  // Note accepted requests and check results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      board.note_request(coord_x_i, coord_y_i, coord_z_i, coord_w_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(noise_value_o);
  end

  // Receiver: random stall bursts, none in the tail, long hold when asked
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegOctaveCount:   board.oct_cnt = val[3:0];
      RegFrequencyStep: board.freq_step = val;
      RegAmplitudeStep: board.amp_step = val;
      default: ;
    endcase
  endtask

  task automatic send_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] cw);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i <= cx; coord_y_i <= cy; coord_z_i <= cz; coord_w_i <= cw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h01FF_FFFF));
      default: return {16'($urandom_range(0, 600)) - 16'd300, 16'($urandom())};
    endcase
  endfunction

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_noise.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  task automatic random_points(int n);
    repeat (n) send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Run limit
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [31:0] ext[6];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0001_0000};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners at reset settings
    for (int i = 0; i < 6; i++) send_point(ext[i], ext[(i+1)%6], ext[(i+2)%6], ext[(i+3)%6]);
    send_point(32'h0121_0000, 32'hFEDF_0000, 32'h0120_8000, 32'h0000_8000);
    drain();

    // Extreme settings: zero octaves and zero steps, then 15 octaves and full steps
    write_reg(RegOctaveCount, 16'd0);
    write_reg(RegFrequencyStep, 16'd0);
    write_reg(RegAmplitudeStep, 16'd0);
    for (int i = 0; i < 4; i++) send_point(ext[i], ext[5-i], ext[i+1], ext[i+2]);
    random_points(4);
    drain();
    write_reg(RegOctaveCount, 16'd15);
    write_reg(RegFrequencyStep, 16'hFFFF);
    write_reg(RegAmplitudeStep, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_point(ext[i], ext[(i+2)%6], ext[(i+4)%6], ext[(i+5)%6]);
    drain();

    // Long receiver hold so the pipeline fills and back-pressures
    write_reg(RegOctaveCount, 16'd8);
    fork
      begin
        hold_off = 1'b1;
        repeat (Latency + 80) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_points(200);
    join
    drain();

    // Random settings between phases
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegOctaveCount, 16'($urandom_range(0, 15)));
      write_reg(RegFrequencyStep, 16'($urandom()));
      write_reg(RegAmplitudeStep, 16'($urandom()));
      random_points(50);
      drain();
    end

    // Quiet tail at default-like settings
    write_reg(RegOctaveCount, 16'd1);
    write_reg(RegFrequencyStep, 16'd8192);
    write_reg(RegAmplitudeStep, 16'd8192);
    quiet_tail = 1'b1;
    random_points(60);
    drain();

    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
